@@ rtl/lkv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value table package
// Shared constants, request codes and controller states.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int REQ_W = 3;
  localparam int OCC_W = 5;
  localparam int CTR_W = 32;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_AW-3:0] REG_CAPACITY = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET         = 3'd0,
    REQ_PUT         = 3'd1,
    REQ_CONTAINS    = 3'd2,
    REQ_REMOVE      = 3'd3,
    REQ_CLEAR       = 3'd4,
    REQ_RESET_STATS = 3'd5
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_t;

endpackage

@@ rtl/lkv_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface lkv_in_if #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
  import lkv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, req_type, lookup_key, write_value, input ready);
  modport sink   (input valid, req_type, lookup_key, write_value, output ready);

endinterface

@@ rtl/lkv_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface lkv_out_if #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
);
  import lkv_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] read_value;
  logic                  did_evict;
  logic [KEY_BITS-1:0]   evicted_key;
  logic [OCC_W-1:0]      occupancy;
  logic [CTR_W-1:0]      hits;
  logic [CTR_W-1:0]      misses;

  modport source (output valid, found, read_value, did_evict, evicted_key, occupancy,
                  hits, misses, input ready);
  modport sink   (input valid, found, read_value, did_evict, evicted_key, occupancy,
                  hits, misses, output ready);

endinterface

@@ rtl/lru_key_value_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key/value table
// Fully associative key/value table with least-recently-used replacement.
//
//   channel   | direction | handshake              | word
//   ----------+-----------+------------------------+---------------------------
//   in_chan   | in        | valid/ready            | req_type, key, value
//   out_chan  | out       | valid/ready            | found .. misses
//   APB       | in        | psel/penable, pready=1 | capacity at addresses 0 to 3
//
// Get, put, contains and remove pass through the scan state: the key and value
// RAM read ports scan one slot per cycle, then the update state follows.
// Clear, reset stats and unused codes go straight to the update state.
// Reset clears valid bits, ages, occupancy, counters and capacity (ENTRIES).
// A new word is taken while the last result still waits in the output register;
// the update cycle holds until that register is free.
// ----------------------------------------------------------------------------
module lru_key_value_table #(
  parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lkv_in_if.sink                     in_chan,
  lkv_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lkv_pkg::CFG_AW-1:0] paddr,
  input  logic [lkv_pkg::CFG_DW-1:0] pwdata,
  output logic [lkv_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import lkv_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int NUM_W = $clog2(ENTRIES + 1);
  localparam logic [NUM_W-1:0] ENTRIES_N = NUM_W'(ENTRIES);

  state_t state_r, state_nxt;

  logic                  valid_r [ENTRIES];
  logic                  valid_nxt [ENTRIES];
  logic [IDX_W-1:0]      age_r [ENTRIES];
  logic [IDX_W-1:0]      age_nxt [ENTRIES];
  logic [NUM_W-1:0]      cnt_r, cnt_nxt;
  logic [NUM_W-1:0]      cap_r;
  logic [CTR_W-1:0]      hits_r, hits_nxt;
  logic [CTR_W-1:0]      miss_r, miss_nxt;

  req_type_t             op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [NUM_W-1:0]      scn_r;

  logic                  hit_r;
  logic [IDX_W-1:0]      hit_idx_r;
  logic [VALUE_BITS-1:0] hit_val_r;
  logic [IDX_W-1:0]      old_idx_r;
  logic [KEY_BITS-1:0]   evk_r;
  logic [IDX_W-1:0]      free_idx_r;

  logic                  out_valid_r;
  logic                  o_found_r, o_found_nxt;
  logic [VALUE_BITS-1:0] o_rd_r, o_rd_nxt;
  logic                  o_ev_r, o_ev_nxt;
  logic [KEY_BITS-1:0]   o_evk_r, o_evk_nxt;
  logic [OCC_W-1:0]      o_occ_r;

  logic                  accept;
  logic                  commit;
  logic                  out_free;
  logic                  cfg_wr;
  logic [NUM_W-1:0]      cap_wr;

  logic [IDX_W-1:0]      raddr;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  cmp_on;
  logic [NUM_W-1:0]      ci_n;
  logic [IDX_W-1:0]      ci;
  logic [NUM_W-1:0]      last_age;

  logic                  evict;
  logic [IDX_W-1:0]      ins_idx;
  logic [IDX_W-1:0]      hit_age;
  logic                  key_we;
  logic                  val_we;
  logic [IDX_W-1:0]      val_waddr;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = CFG_DW'(cap_r);
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_CAPACITY);

  always_comb begin
    if (pwdata == '0) begin
      cap_wr = NUM_W'(1);
    end else if (pwdata > CFG_DW'(ENTRIES)) begin
      cap_wr = ENTRIES_N;
    end else begin
      cap_wr = pwdata[NUM_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_chan.req_type == REQ_GET) || (in_chan.req_type == REQ_PUT) ||
              (in_chan.req_type == REQ_CONTAINS) || (in_chan.req_type == REQ_REMOVE)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_SCAN: begin
        if (scn_r == ENTRIES_N) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    out_free      = !out_valid_r || out_chan.ready;
    commit        = (state_r == ST_EXEC) && out_free;
    cmp_on        = (state_r == ST_SCAN) && (scn_r != '0);
  end

  assign accept = in_chan.valid && in_chan.ready;

  // Slot scan
  assign raddr    = (scn_r < ENTRIES_N) ? scn_r[IDX_W-1:0] : '0;
  assign ci_n     = scn_r - NUM_W'(1);
  assign ci       = ci_n[IDX_W-1:0];
  assign last_age = cnt_r - NUM_W'(1);

  lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (ins_idx),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (key_rd)
  );

  lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (val_rd)
  );

  // Update
  assign evict   = (op_r == REQ_PUT) && !hit_r && (cnt_r >= cap_r);
  assign ins_idx = evict ? old_idx_r : free_idx_r;
  assign hit_age = age_r[hit_idx_r];

  always_comb begin
    valid_nxt   = valid_r;
    age_nxt     = age_r;
    cnt_nxt     = cnt_r;
    hits_nxt    = hits_r;
    miss_nxt    = miss_r;
    o_found_nxt = 1'b0;
    o_rd_nxt    = '0;
    o_ev_nxt    = 1'b0;
    o_evk_nxt   = '0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    val_waddr   = hit_idx_r;
    case (op_r)
      REQ_GET: begin
        o_found_nxt = hit_r;
        if (hit_r) begin
          o_rd_nxt = hit_val_r;
          if (hits_r != '1) begin
            hits_nxt = hits_r + CTR_W'(1);
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && (age_r[i] < hit_age)) begin
              age_nxt[i] = age_r[i] + IDX_W'(1);
            end
          end
          age_nxt[hit_idx_r] = '0;
        end else if (miss_r != '1) begin
          miss_nxt = miss_r + CTR_W'(1);
        end
      end
      REQ_PUT: begin
        o_found_nxt = hit_r;
        val_we      = commit;
        if (hit_r) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && (age_r[i] < hit_age)) begin
              age_nxt[i] = age_r[i] + IDX_W'(1);
            end
          end
          age_nxt[hit_idx_r] = '0;
        end else begin
          key_we    = commit;
          val_waddr = ins_idx;
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i]) begin
              age_nxt[i] = age_r[i] + IDX_W'(1);
            end
          end
          valid_nxt[ins_idx] = 1'b1;
          age_nxt[ins_idx]   = '0;
          if (evict) begin
            o_ev_nxt  = 1'b1;
            o_evk_nxt = evk_r;
          end else begin
            cnt_nxt = cnt_r + NUM_W'(1);
          end
        end
      end
      REQ_CONTAINS: begin
        o_found_nxt = hit_r;
      end
      REQ_REMOVE: begin
        o_found_nxt = hit_r;
        if (hit_r) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && (age_r[i] > hit_age)) begin
              age_nxt[i] = age_r[i] - IDX_W'(1);
            end
          end
          valid_nxt[hit_idx_r] = 1'b0;
          age_nxt[hit_idx_r]   = '0;
          cnt_nxt              = cnt_r - NUM_W'(1);
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          valid_nxt[i] = 1'b0;
          age_nxt[i]   = '0;
        end
        cnt_nxt  = '0;
        hits_nxt = '0;
        miss_nxt = '0;
      end
      REQ_RESET_STATS: begin
        hits_nxt = '0;
        miss_nxt = '0;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cap_r       <= ENTRIES_N;
      hits_r      <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
      scn_r       <= '0;
      hit_r       <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
        age_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && (cnt_r == '0)) begin
        cap_r <= cap_wr;
      end
      if (accept) begin
        scn_r <= '0;
        hit_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        scn_r <= scn_r + NUM_W'(1);
        if (cmp_on && valid_r[ci] && (key_rd == key_r)) begin
          hit_r <= 1'b1;
        end
      end
      if (commit) begin
        valid_r     <= valid_nxt;
        age_r       <= age_nxt;
        cnt_r       <= cnt_nxt;
        hits_r      <= hits_nxt;
        miss_r      <= miss_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= req_type_t'(in_chan.req_type);
      key_r <= in_chan.lookup_key;
      val_r <= in_chan.write_value;
    end
    if (cmp_on) begin
      if (valid_r[ci] && (key_rd == key_r)) begin
        hit_idx_r <= ci;
        hit_val_r <= val_rd;
      end
      if (valid_r[ci] && (NUM_W'(age_r[ci]) == last_age)) begin
        old_idx_r <= ci;
        evk_r     <= key_rd;
      end
      if (!valid_r[ci]) begin
        free_idx_r <= ci;
      end
    end
    if (commit) begin
      o_found_r <= o_found_nxt;
      o_rd_r    <= o_rd_nxt;
      o_ev_r    <= o_ev_nxt;
      o_evk_r   <= o_evk_nxt;
      o_occ_r   <= OCC_W'(cnt_nxt);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = o_found_r;
  assign out_chan.read_value  = o_rd_r;
  assign out_chan.did_evict   = o_ev_r;
  assign out_chan.evicted_key = o_evk_r;
  assign out_chan.occupancy   = o_occ_r;
  assign out_chan.hits        = hits_r;
  assign out_chan.misses      = miss_r;

endmodule

@@ rtl/lkv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lkv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU table checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker #(
  parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  found,
  input logic [VALUE_BITS-1:0] read_value,
  input logic                  did_evict,
  input logic [KEY_BITS-1:0]   evicted_key
);
  import lkv_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_miss_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (found || (read_value == '0)))
    else $error("read value on a miss");

  a_evict_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (did_evict || (evicted_key == '0)))
    else $error("evicted key without eviction");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && did_evict |-> !found)
    else $error("eviction on a hit");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word after reset");

endmodule

bind lru_key_value_table lkv_checker #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .found       (out_chan.found),
  .read_value  (out_chan.read_value),
  .did_evict   (out_chan.did_evict),
  .evicted_key (out_chan.evicted_key)
);
